// File: src/http_chunked_body_decoder_unit_defines.svh
// Assertion helpers for the chunked body decoder.
// Both forms sample on the rising clock edge and are off while reset is high.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The condition in the same cycle implies the consequence.
`define HCBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbd check failed");
// The condition implies the consequence in the next cycle.
`define HCBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbd check failed");
`else
`define HCBD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define HCBD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: src/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Reported status
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_GOOD  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Decoder phases
  localparam logic [2:0] PH_SIZE      = 3'd0;
  localparam logic [2:0] PH_SKIP_SIZE = 3'd1;
  localparam logic [2:0] PH_DATA      = 3'd2;
  localparam logic [2:0] PH_SKIP_DATA = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;
  localparam logic [2:0] PH_ERROR     = 3'd5;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [3:0] HEX_TEN  = 4'd10;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
  } hcbd_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [1:0]  status;
    logic [31:0] decoded_count;
  } hcbd_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hcbd_hex_t;

  // Decode one hex digit in either case
  function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
    hcbd_hex_t h;
    h.is_hex = 1'b0;
    h.value  = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - CH_ZERO);
    end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - CH_LOW_A) + HEX_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      h.is_hex = 1'b1;
      h.value  = 4'(c - CH_UP_A) + HEX_TEN;
    end
    return h;
  endfunction

  function automatic logic is_crlf(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

// File: src/http_chunked_body_decoder_unit.sv
`timescale 1ns / 1ps
// Channel  Valid       Ready       Payload    Content
// input    item_valid  item_ready  item_data  op, in_byte
// result   res_valid   res_ready   res_data   out_byte, out_valid, status, decoded_count
//
// One result beat for every input beat, one beat per cycle sustained while res_ready stays high.
// Each beat passes through the input register, then is decoded into the result register.
// The decode state (phase, size, counters) is updated in the same cycle as the
// result register, so a beat uses the state left by the beat just before it.
// rst clears the state to the start of a body; a stalled result holds the input
// register, and item_ready drops only when both registers are full.
`include "http_chunked_body_decoder_unit_defines.svh"

module http_chunked_body_decoder_unit
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  hcbd_item_t   item_data,
  output logic         res_valid,
  input  logic         res_ready,
  output hcbd_result_t res_data
);

  // Input register
  logic       v1;
  hcbd_item_t item1;

  // Decode state
  logic [2:0]           phase;
  logic                 digits_seen;
  logic [SIZE_BITS-1:0] chunk_remaining;
  logic [31:0]          emitted_total;

  logic [2:0]           phase_next;
  logic                 digits_seen_next;
  logic [SIZE_BITS-1:0] chunk_remaining_next;
  logic [31:0]          emitted_total_next;
  hcbd_result_t         res_data_next;

  logic      adv;
  logic      fire;
  hcbd_hex_t hex;
  logic      crlf;
  logic      take;
  logic      add;
  logic      size_full;
  logic [SIZE_BITS-1:0] rem_dec;

  // Advance when the result register is free or being drained
  assign adv        = !res_valid || res_ready;
  assign fire       = adv && v1;
  assign item_ready = !v1 || adv;

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (item_ready) begin
      v1 <= item_valid;
    end
    if (item_ready && item_valid) begin
      item1 <= item_data;
    end
  end

  assign hex       = hex_decode(item1.in_byte);
  assign crlf      = is_crlf(item1.in_byte);
  assign size_full = |chunk_remaining[SIZE_BITS-1 -: 4];
  assign rem_dec   = chunk_remaining - SIZE_BITS'(1);

  // Decode one beat against the current state
  always_comb begin
    phase_next           = phase;
    digits_seen_next     = digits_seen;
    chunk_remaining_next = chunk_remaining;
    emitted_total_next   = emitted_total;
    take                 = 1'b0;
    add                  = 1'b0;
    res_data_next.out_byte  = 8'd0;
    res_data_next.out_valid = 1'b0;
    case (item1.op)
      OP_START: begin
        phase_next           = PH_SIZE;
        digits_seen_next     = 1'b0;
        chunk_remaining_next = '0;
        emitted_total_next   = 32'd0;
      end
      OP_BYTE: begin
        case (phase)
          PH_SIZE: begin
            if (hex.is_hex) begin
              add = 1'b1;
            end else if (!digits_seen) begin
              phase_next = PH_ERROR;
            end else if (chunk_remaining == '0) begin
              phase_next = PH_DONE;
            end else if (crlf) begin
              phase_next = PH_SKIP_SIZE;
            end else begin
              take = 1'b1;
            end
          end
          PH_SKIP_SIZE: begin
            take = !crlf;
          end
          PH_DATA: begin
            take = 1'b1;
          end
          PH_SKIP_DATA: begin
            if (!crlf) begin
              if (!hex.is_hex) begin
                phase_next = PH_ERROR;
              end else begin
                // New size from a cleared register cannot overflow
                phase_next           = PH_SIZE;
                digits_seen_next     = 1'b1;
                chunk_remaining_next = SIZE_BITS'(hex.value);
              end
            end
          end
          default: begin
          end
        endcase
      end
      OP_END: begin
        case (phase)
          PH_SIZE:      phase_next = digits_seen ? PH_ERROR : PH_DONE;
          PH_SKIP_SIZE: phase_next = PH_ERROR;
          PH_DATA:      phase_next = PH_ERROR;
          PH_SKIP_DATA: phase_next = PH_DONE;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Shift in one size digit, flag overflow
    if (add) begin
      if (size_full) begin
        phase_next = PH_ERROR;
      end else begin
        chunk_remaining_next = {chunk_remaining[SIZE_BITS-5:0], hex.value};
        digits_seen_next     = 1'b1;
      end
    end

    // Pass one data byte
    if (take) begin
      res_data_next.out_byte  = item1.in_byte;
      res_data_next.out_valid = 1'b1;
      emitted_total_next      = emitted_total + 32'd1;
      chunk_remaining_next    = rem_dec;
      phase_next              = (rem_dec == '0) ? PH_SKIP_DATA : PH_DATA;
    end

    case (phase_next)
      PH_DONE:  res_data_next.status = ST_GOOD;
      PH_ERROR: res_data_next.status = ST_ERROR;
      default:  res_data_next.status = ST_BUSY;
    endcase
    res_data_next.decoded_count = emitted_total_next;
  end

  // Update state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      digits_seen     <= 1'b0;
      chunk_remaining <= '0;
      emitted_total   <= 32'd0;
      res_valid       <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= v1;
      end
      if (fire) begin
        phase           <= phase_next;
        digits_seen     <= digits_seen_next;
        chunk_remaining <= chunk_remaining_next;
        emitted_total   <= emitted_total_next;
      end
    end
    if (fire) begin
      res_data <= res_data_next;
    end
  end

  // A data byte is only produced while the body is still open
  `HCBD_ASSERT_IMP(a_data_busy, clk, rst, res_valid && res_data.out_valid, res_data.status == ST_BUSY)
  // Data phase always has bytes still due
  `HCBD_ASSERT_IMP(a_data_nonzero, clk, rst, phase == PH_DATA, chunk_remaining != '0)
  // A finished body holds its phase until a new start
  `HCBD_ASSERT_NXT(a_finish_hold, clk, rst, (phase == PH_DONE || phase == PH_ERROR) && !(fire && item1.op == OP_START), phase == $past(phase))
  // A draining result side never throttles the input
  `HCBD_ASSERT_IMP(a_no_bubble, clk, rst, res_ready, item_ready)

endmodule
